// ----- hdl/cht_pkg.sv -----
// Shared codes and fixed field widths for the chained hash table engine.
// No dependencies; every other file but cht_ram imports this package.
package cht_pkg;

  // Field widths fixed by the command and response formats.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 9;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  // Response status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

endpackage

// ----- hdl/cht_if.sv -----
// Valid/ready channel interfaces for the command and response streams.
// Depends on cht_pkg for the field widths.
interface cht_cmd_if import cht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
  modport mon    (input valid, input command, input key, input value, input ready);
endinterface

interface cht_rsp_if import cht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [VAL_W-1:0]   read_value;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
  modport mon    (input valid, input status, input read_value, input entry_count,
                  input ready);
endinterface

// ----- hdl/cht_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/chained_hash_table_engine_core.sv -----
// Top level of the chained hash table engine: command FSM, free list and two RAMs.
// Depends on cht_pkg, cht_if (cht_cmd_if, cht_rsp_if) and cht_ram.
//
// Key/value table with separate chaining over ENTRIES nodes (a power of two). After
// reset the whole bucket-head RAM is cleared, and no command beat is taken meanwhile.
// Each command then takes one beat and returns exactly one response beat. Insert
// passes through S_HEAD, S_ALLOC and S_RESP; read, write and remove pass through
// S_HEAD, then S_WALK once per chain node visited (one node-RAM read per cycle), then
// S_RESP, with S_ALLOC before it for a write that allocates and S_REM2 for a remove
// that finds its key. The rate is set by the chain walk through the node RAM. A new
// command is taken while the previous response still waits in the output register;
// that command then holds in its last cycle until the waiting response beat is taken.
module chained_hash_table_engine_core import cht_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input logic          clk,
  input logic          rst_n,
  cht_cmd_if.sink      in_cmd,
  cht_rsp_if.source    out_rsp
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] EMPTY = LW'(ENTRIES);

  typedef struct packed {
    logic [LW-1:0]    link;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_WALK, S_ALLOC, S_REM2, S_RESP
  } state_t;

  state_t             state_r;
  logic [IW-1:0]      clr_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;
  logic [LW-1:0]      free_head_r;
  logic [LW-1:0]      hw_r;
  logic [LW-1:0]      count_r;
  logic [LW-1:0]      cur_r;
  logic [LW-1:0]      pred_r;
  node_t              pred_node_r;
  node_t              fnd_node_r;
  logic [LW-1:0]      old_head_r;
  logic [LW-1:0]      free_nxt_r;
  logic [IW-1:0]      walk_cnt_r;
  logic [STAT_W-1:0]  status_r;
  logic [VAL_W-1:0]   rv_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [VAL_W-1:0]   out_rv_r;
  logic [COUNT_W-1:0] out_count_r;

  // RAM ports.
  logic          head_wr_en, head_rd_en;
  logic [IW-1:0] head_wr_addr, head_rd_addr;
  logic [LW-1:0] head_wr_data, head_q;
  logic          node_wr_en, node_rd_en;
  logic [IW-1:0] node_wr_addr, node_rd_addr;
  node_t         node_wr_data, node_q;

  logic          in_fire;
  logic          key_match;
  logic          walk_end;
  logic          full;

  cht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_head_ram (
    .clk     (clk),
    .wr_en   (head_wr_en),
    .wr_addr (head_wr_addr),
    .wr_data (head_wr_data),
    .rd_en   (head_rd_en),
    .rd_addr (head_rd_addr),
    .rd_data (head_q)
  );

  cht_ram #(.WIDTH(NODE_W), .DEPTH(ENTRIES)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_q)
  );

  // Handshake and walk decisions. A link with the top bit set is outside the table.
  assign in_cmd.ready = (state_r == S_IDLE);
  assign in_fire      = in_cmd.valid && (state_r == S_IDLE);
  assign key_match    = (node_q.key == key_r);
  assign walk_end     = node_q.link[LW-1] || (walk_cnt_r == '1);
  assign full         = free_head_r[LW-1];

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.read_value  = out_rv_r;
  assign out_rsp.entry_count = out_count_r;

  // Memory access control: reads are issued in the state before the one that uses them.
  always_comb begin
    head_rd_en   = in_fire;
    head_rd_addr = in_cmd.key[IW-1:0];
    head_wr_en   = 1'b0;
    head_wr_addr = key_r[IW-1:0];
    head_wr_data = free_head_r;
    node_rd_en   = 1'b0;
    node_rd_addr = free_head_r[IW-1:0];
    node_wr_en   = 1'b0;
    node_wr_addr = cur_r[IW-1:0];
    node_wr_data = node_q;
    case (state_r)
      S_CLEAR: begin
        head_wr_en   = 1'b1;
        head_wr_addr = clr_r;
        head_wr_data = EMPTY;
      end
      S_IDLE: begin
        // Fetch the free-list head node to learn its successor.
        node_rd_en = in_fire;
      end
      S_HEAD: begin
        node_rd_en   = (cmd_r != CMD_INSERT) && !head_q[LW-1];
        node_rd_addr = head_q[IW-1:0];
      end
      S_WALK: begin
        if (key_match) begin
          if (cmd_r == CMD_WRITE) begin
            node_wr_en   = 1'b1;
            node_wr_data = '{link: node_q.link, key: node_q.key, value: val_r};
          end else if (cmd_r == CMD_REMOVE) begin
            node_wr_en   = 1'b1;
            node_wr_data = '{link: free_head_r, key: node_q.key, value: '0};
          end
        end else begin
          node_rd_en   = !walk_end;
          node_rd_addr = node_q.link[IW-1:0];
        end
      end
      S_ALLOC: begin
        head_wr_en   = !full;
        node_wr_en   = !full;
        node_wr_addr = free_head_r[IW-1:0];
        node_wr_data = '{link: old_head_r, key: key_r, value: val_r};
      end
      S_REM2: begin
        // Unlink the removed node from its predecessor or from the bucket head.
        head_wr_en   = pred_r[LW-1];
        head_wr_data = fnd_node_r.link;
        node_wr_en   = !pred_r[LW-1];
        node_wr_addr = pred_r[IW-1:0];
        node_wr_data = '{link: fnd_node_r.link, key: pred_node_r.key,
                         value: pred_node_r.value};
      end
      default: begin
      end
    endcase
  end

  // Command FSM, free list, entry count and the response register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      hw_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_RESP a taken beat is always replaced by the new one below.
      if (out_rsp.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_r   <= in_cmd.command;
            key_r   <= in_cmd.key;
            val_r   <= in_cmd.value;
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          old_head_r <= head_q;
          cur_r      <= head_q;
          pred_r     <= EMPTY;
          walk_cnt_r <= '0;
          rv_r       <= '0;
          // Nodes at or above the high-water mark were never used and link in order.
          free_nxt_r <= (free_head_r == hw_r) ? hw_r + 1'b1 : node_q.link;
          if (cmd_r == CMD_INSERT) begin
            state_r <= S_ALLOC;
          end else if (head_q[LW-1]) begin
            if (cmd_r == CMD_WRITE) begin
              state_r <= S_ALLOC;
            end else begin
              status_r <= STAT_NOT_FOUND;
              state_r  <= S_RESP;
            end
          end else begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (key_match) begin
            status_r <= STAT_OK;
            case (cmd_r)
              CMD_READ: begin
                rv_r    <= node_q.value;
                state_r <= S_RESP;
              end
              CMD_REMOVE: begin
                fnd_node_r  <= node_q;
                free_head_r <= cur_r;
                count_r     <= count_r - 1'b1;
                state_r     <= S_REM2;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end else begin
            pred_r      <= cur_r;
            pred_node_r <= node_q;
            cur_r       <= node_q.link;
            walk_cnt_r  <= walk_cnt_r + 1'b1;
            if (walk_end) begin
              if (cmd_r == CMD_WRITE) begin
                state_r <= S_ALLOC;
              end else begin
                status_r <= STAT_NOT_FOUND;
                state_r  <= S_RESP;
              end
            end
          end
        end
        S_ALLOC: begin
          if (full) begin
            status_r <= STAT_FULL;
          end else begin
            status_r    <= STAT_OK;
            free_head_r <= free_nxt_r;
            count_r     <= count_r + 1'b1;
            if (free_head_r == hw_r) begin
              hw_r <= hw_r + 1'b1;
            end
          end
          state_r <= S_RESP;
        end
        S_REM2: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_rv_r     <= rv_r;
            out_count_r  <= COUNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/cht_checker.sv -----
// Port-level assertions for the chained hash table engine, bound to the top level.
// Depends on cht_pkg and cht_if; attaches to chained_hash_table_engine_core.
module cht_checker import cht_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input logic        clk,
  input logic        rst_n,
  cht_rsp_if.source  out_rsp
);

  // No response beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_rsp.valid)
    else $error("response valid after reset");

  // Only a successful command can return a nonzero value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status != STAT_OK) |-> (out_rsp.read_value == '0))
    else $error("nonzero read value on a failed command");

  // A full-table response means every node is in use.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status == STAT_FULL)
      |-> (out_rsp.entry_count == COUNT_W'(ENTRIES)))
    else $error("table full reported with free nodes");

  // Status is one of the three defined codes.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.status == STAT_OK) || (out_rsp.status == STAT_NOT_FOUND)
                      || (out_rsp.status == STAT_FULL))
    else $error("undefined status code");

  // A stalled response beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(out_rsp.status)
      && $stable(out_rsp.read_value) && $stable(out_rsp.entry_count))
    else $error("stalled response changed");

endmodule

bind chained_hash_table_engine_core cht_checker #(.ENTRIES(ENTRIES)) u_cht_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .out_rsp (out_rsp)
);
